// ----- hw/rtl/bcuv_pkg.sv -----
// Package for the battery cell count and undervoltage block.
// Holds widths, register indexes, reset values, the pack class codes and the register struct.
// No dependencies.
`default_nettype none

package bcuv_pkg;

   localparam int ADC_BITS  = 12;
   localparam int SAMPLE_W  = 12;
   localparam int SCALE_W   = 20;
   localparam int MV_W      = 16;
   localparam int CELL_MV_W = 14;
   localparam int CLASS_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int PROD_W    = SAMPLE_W + SCALE_W;
   localparam int FRAC_W    = 16;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Q16      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASSIFY_DELAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_CELL_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THREE_CELL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_LOW       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_HOLD       = 3'd5;

   localparam logic [SCALE_W-1:0]   RST_SCALE_Q16      = 20'd301035;
   localparam logic [MV_W-1:0]      RST_CLASSIFY_DELAY = 16'd1000;
   localparam logic [MV_W-1:0]      RST_TWO_CELL_LIMIT = 16'd9000;
   localparam logic [MV_W-1:0]      RST_THREE_CELL_LIMIT = 16'd13000;
   localparam logic [CELL_MV_W-1:0] RST_CELL_LOW       = 14'd3300;
   localparam logic [MV_W-1:0]      RST_LOW_HOLD       = 16'd3000;

   typedef enum logic [CLASS_W-1:0] {
      CLS_UNKNOWN = 3'd0,
      CLS_2S      = 3'd1,
      CLS_3S      = 3'd2,
      CLS_4S      = 3'd3,
      CLS_LOW     = 3'd4
   } pack_class_type;

   typedef struct packed {
      logic [SCALE_W-1:0]   scale_q16;
      logic [MV_W-1:0]      classify_delay;
      logic [MV_W-1:0]      two_cell_limit_mv;
      logic [MV_W-1:0]      three_cell_limit_mv;
      logic [CELL_MV_W-1:0] cell_low_mv;
      logic [MV_W-1:0]      low_hold;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bcuv_csr.sv -----
// Configuration registers of the battery cell count and undervoltage block.
// Depends on bcuv_pkg for indexes, reset values and the register struct.
`default_nettype none

module bcuv_csr
   import bcuv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE_Q16:        cfg_in.scale_q16 = csr_wdata[SCALE_W-1:0];
            CSR_CLASSIFY_DELAY:   cfg_in.classify_delay = csr_wdata[MV_W-1:0];
            CSR_TWO_CELL_LIMIT:   cfg_in.two_cell_limit_mv = csr_wdata[MV_W-1:0];
            CSR_THREE_CELL_LIMIT: cfg_in.three_cell_limit_mv = csr_wdata[MV_W-1:0];
            CSR_CELL_LOW:         cfg_in.cell_low_mv = csr_wdata[CELL_MV_W-1:0];
            CSR_LOW_HOLD:         cfg_in.low_hold = csr_wdata[MV_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_q16           <= RST_SCALE_Q16;
         cfg_ff.classify_delay      <= RST_CLASSIFY_DELAY;
         cfg_ff.two_cell_limit_mv   <= RST_TWO_CELL_LIMIT;
         cfg_ff.three_cell_limit_mv <= RST_THREE_CELL_LIMIT;
         cfg_ff.cell_low_mv         <= RST_CELL_LOW;
         cfg_ff.low_hold            <= RST_LOW_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bcuv_scale.sv -----
// Input register and millivolt scaling stage: sample times Q16 scale, truncated.
// Depends on bcuv_pkg for widths and the sample mask.
`default_nettype none

module bcuv_scale
   import bcuv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [SAMPLE_W-1:0] req_adc_sample,
   input  wire logic [SCALE_W-1:0]  scale_q16,
   output      logic                mid_valid,
   input  wire logic                mid_ready,
   output      logic [MV_W-1:0]     mid_volt
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s2_valid_ff;
   logic                s2_valid_in;
   logic [MV_W-1:0]     s2_volt_ff;
   logic [MV_W-1:0]     s2_volt_in;
   logic                s1_ready;
   logic                s2_ready;
   logic [PROD_W-1:0]   product;
   logic [PROD_W-FRAC_W-1:0] shifted;

   assign s2_ready  = !s2_valid_ff || mid_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign product = PROD_W'(s1_sample_ff) * PROD_W'(scale_q16);
   assign shifted = product[PROD_W-1:FRAC_W];

   // A 12-bit sample times a 20-bit scale, shifted down by 16, never exceeds 16 bits.
   assign s2_volt_in = shifted;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_sample_ff <= req_adc_sample & SAMPLE_MASK;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_volt_ff <= s2_volt_in;
      end
   end

   assign mid_valid = s2_valid_ff;
   assign mid_volt  = s2_volt_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bcuv_classify.sv -----
// Pack classification, low-run tracking and the result register.
// Depends on bcuv_pkg for the class codes and the register struct.
`default_nettype none

module bcuv_classify
   import bcuv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               mid_valid,
   output      logic               mid_ready,
   input  wire logic [MV_W-1:0]    mid_volt,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [MV_W-1:0]    rsp_voltage_mv,
   output      logic [CLASS_W-1:0] rsp_pack_class
);

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [MV_W-1:0] rsp_volt_ff;
   logic [MV_W-1:0] count_ff;
   logic [MV_W-1:0] count_in;
   logic [MV_W-1:0] run_ff;
   logic [MV_W-1:0] run_in;
   pack_class_type state_ff;
   pack_class_type state_in;
   pack_class_type cls;
   logic [MV_W-1:0] thr;
   logic           take;

   assign mid_ready = !rsp_valid_ff || rsp_ready;
   assign take      = mid_valid && mid_ready;

   always_comb begin
      count_in = (count_ff != '1) ? count_ff + 1'b1 : count_ff;

      cls = state_ff;
      if (state_ff == CLS_UNKNOWN && count_in > cfg.classify_delay) begin
         if (mid_volt < cfg.two_cell_limit_mv) begin
            cls = CLS_2S;
         end else if (mid_volt < cfg.three_cell_limit_mv) begin
            cls = CLS_3S;
         end else begin
            cls = CLS_4S;
         end
      end

      unique case (cls)
         CLS_2S:  thr = {1'b0, cfg.cell_low_mv, 1'b0};
         CLS_3S:  thr = MV_W'(cfg.cell_low_mv) + {1'b0, cfg.cell_low_mv, 1'b0};
         CLS_4S:  thr = {cfg.cell_low_mv, 2'b00};
         default: thr = '0;
      endcase

      run_in   = run_ff;
      state_in = cls;
      if (cls != CLS_LOW) begin
         if (thr > mid_volt) begin
            run_in = (run_ff != '1) ? run_ff + 1'b1 : run_ff;
         end else begin
            run_in = '0;
         end
         if (run_in > cfg.low_hold) begin
            state_in = CLS_LOW;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (mid_ready) begin
         rsp_valid_in = mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         run_ff       <= '0;
         state_ff     <= CLS_UNKNOWN;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            count_ff <= count_in;
            run_ff   <= run_in;
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_volt_ff <= mid_volt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voltage_mv = rsp_volt_ff;
   assign rsp_pack_class = CLASS_W'(state_ff);

endmodule

`default_nettype wire

// ----- hw/rtl/battery_cell_count_and_undervoltage_top.sv -----
// Top level of the battery cell count and undervoltage block.
// Depends on bcuv_pkg, bcuv_csr, bcuv_scale and bcuv_classify.
//
// Usage:
// Each request on the req_ channel carries one raw ADC sample. Every request
// yields exactly one response on the rsp_ channel with the voltage in
// millivolts and the pack class after that sample (0 unknown, 1 2S, 2 3S,
// 3 4S, 4 low). Both channels use valid and ready.
// A request passes an input register, a scaling multiply register and the
// result register. The input register loads at the accepting edge, and the
// response becomes valid once the scaling and result registers have loaded.
// While rsp_ready stays high, the block takes a new request every cycle;
// throughput is one sample per cycle, set by the single multiplier stage and
// the state update of each sample. When the receiver holds rsp_ready low, the
// three stages fill and req_ready falls only once all of them are full; no response is dropped.
// Reset is synchronous and active high. It loads the register defaults,
// clears the sample and low-run counters and sets the pack class to unknown.
// The csr_ port writes one register per cycle with csr_we high; it should be
// written only while no request is in flight.
`default_nettype none

module battery_cell_count_and_undervoltage_top
   import bcuv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [SAMPLE_W-1:0]   req_adc_sample,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [MV_W-1:0]       rsp_voltage_mv,
   output      logic [CLASS_W-1:0]    rsp_pack_class,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg;
   logic            mid_valid;
   logic            mid_ready;
   logic [MV_W-1:0] mid_volt;

   bcuv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcuv_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .scale_q16      (cfg.scale_q16),
      .mid_valid      (mid_valid),
      .mid_ready      (mid_ready),
      .mid_volt       (mid_volt)
   );

   bcuv_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .mid_valid      (mid_valid),
      .mid_ready      (mid_ready),
      .mid_volt       (mid_volt),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_voltage_mv (rsp_voltage_mv),
      .rsp_pack_class (rsp_pack_class)
   );

endmodule

`default_nettype wire
